// ----- rtl/vgnq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgnq_pkg
// Shared types and constants for the voxel grid neighbor query block.
// ----------------------------------------------------------------------------
package vgnq_pkg;

  // Fixed field widths.
  localparam int CMD_W   = 2;
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int WVAL_W  = 16;
  localparam int OUT_W   = 16;

  // Address arithmetic widths: y*sx, z*(sx*sy) and the final sum.
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int ZPROD_W = PROD_W + SIZE_W;
  localparam int LIN_W   = ZPROD_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Neighbor offset codes: -1, 0 and +1 stored as 0, 1 and 2.
  localparam logic [1:0] OFS_LO  = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_HI  = 2'd2;

  // Location of one visited voxel, handed from the address unit.
  typedef struct packed {
    logic              in_grid;
    logic [SIZE_W-1:0] x;
    logic [SIZE_W-1:0] y;
    logic [SIZE_W-1:0] z;
  } loc_t;

endpackage
`default_nettype wire

// ----- rtl/vgnq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgnq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vgnq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read share the address; read data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/vgnq_addr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgnq_addr
// Neighbor location and linear store address x + y*sx + z*sx*sy.
// ----------------------------------------------------------------------------
module vgnq_addr #(
  parameter int MAX_DIM = 32,
  parameter int ADDR_W  = 15
) (
  input  logic                          clk_i,
  input  logic [vgnq_pkg::SIZE_W-1:0]   size_x_i,
  input  logic [vgnq_pkg::SIZE_W-1:0]   size_y_i,
  input  logic [vgnq_pkg::SIZE_W-1:0]   size_z_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  cx_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  cy_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  cz_i,
  input  logic [1:0]                    dx_i,
  input  logic [1:0]                    dy_i,
  input  logic [1:0]                    dz_i,
  output vgnq_pkg::loc_t                loc_o,
  output logic [ADDR_W-1:0]             addr_o
);
  import vgnq_pkg::*;

  localparam int SIZE_MAX = (1 << SIZE_W) - 1;
  localparam int DIM_CAP  = (MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM;
  localparam logic [SIZE_W-1:0] DIM_CAP_V = SIZE_W'(DIM_CAP);

  // A size of zero acts as one; a size above the grid limit is clamped.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > DIM_CAP_V) begin
      r = DIM_CAP_V;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]  sx, sy, sz;
  logic [SIZE_W-1:0]  x6, y6, z6;
  logic [PROD_W-1:0]  sxsy_q;
  logic [PROD_W-1:0]  y_term;
  logic [ZPROD_W-1:0] z_term;
  logic [LIN_W-1:0]   lin;

  assign sx = eff_size(size_x_i);
  assign sy = eff_size(size_y_i);
  assign sz = eff_size(size_z_i);

  // Plane size is registered so only one product stands in each address path.
  always_ff @(posedge clk_i) begin
    sxsy_q <= {{SIZE_W{1'b0}}, sx} * {{SIZE_W{1'b0}}, sy};
  end

  // Neighbor coordinate; minus one from zero wraps high and falls outside.
  assign x6 = SIZE_W'(cx_i) + SIZE_W'(dx_i) - SIZE_W'(1);
  assign y6 = SIZE_W'(cy_i) + SIZE_W'(dy_i) - SIZE_W'(1);
  assign z6 = SIZE_W'(cz_i) + SIZE_W'(dz_i) - SIZE_W'(1);

  assign loc_o.in_grid = (x6 < sx) && (y6 < sy) && (z6 < sz);
  assign loc_o.x       = x6;
  assign loc_o.y       = y6;
  assign loc_o.z       = z6;

  // Linear address; only meaningful when the location is inside the grid.
  assign y_term = {{SIZE_W{1'b0}}, y6} * {{SIZE_W{1'b0}}, sx};
  assign z_term = {{PROD_W{1'b0}}, z6} * {{SIZE_W{1'b0}}, sxsy_q};
  assign lin    = LIN_W'(x6) + LIN_W'(y_term) + LIN_W'(z_term);
  assign addr_o = ADDR_W'(lin);

endmodule
`default_nettype wire

// ----- rtl/voxel_grid_neighbor_query.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_grid_neighbor_query
// Dense voxel store with write, read, filled count and 26-neighbor query.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_* channel (valid/ready) and results leave on the
//   out_* channel (valid/ready). One command is worked on at a time; the next
//   command is taken as soon as the previous one has put its last result into
//   the output register, even while that result still waits to be taken.
//   Write, read and count pass through the execute and data states and then
//   offer their one result; the next command can be taken as it is offered.
//   A neighbor query walks all 27 offsets through the single store port, one
//   offset per cycle while no stall holds it, with the read of one offset
//   overlapping the check of the one before. The next command can be taken
//   as soon as the last result is offered. Every filled neighbor gives one
//   result, and the last one is flagged once the walk has ended; with no
//   filled neighbor a single not-found result is flagged last instead.
//   After reset the store is swept to zero, one entry per cycle, over all
//   MAX_DIM**3 entries (32768 by default); no command is taken meanwhile, but
//   size writes on the cfg_* port are accepted at any time.
//   When the receiver stalls, the query pipeline holds its read data and a
//   pending result and resumes without loss once the output register frees.
// ----------------------------------------------------------------------------
module voxel_grid_neighbor_query #(
  parameter int MAX_DIM    = 32,
  parameter int VALUE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [vgnq_pkg::SIZE_W-1:0]   cfg_data_i,
  // Command channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [vgnq_pkg::CMD_W-1:0]    cmd_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [vgnq_pkg::COORD_W-1:0]  coord_z_i,
  input  logic [vgnq_pkg::WVAL_W-1:0]   write_value_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vgnq_pkg::OUT_W-1:0]    read_value_o,
  output logic                          found_o,
  output logic [vgnq_pkg::COORD_W-1:0]  nbr_x_o,
  output logic [vgnq_pkg::COORD_W-1:0]  nbr_y_o,
  output logic [vgnq_pkg::COORD_W-1:0]  nbr_z_o,
  output logic [vgnq_pkg::OUT_W-1:0]    filled_total_o,
  output logic                          status_o,
  output logic                          last_o
);
  import vgnq_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(DEPTH);

  // Sequencer state codes.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DATA  = 3'd3;
  localparam logic [2:0] S_QUERY = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [SIZE_W-1:0]     size_x_q, size_y_q, size_z_q;
  logic [ADDR_W-1:0]     clr_q, clr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Command held while it is worked on.
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [COORD_W-1:0]    cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [VALUE_BITS-1:0] wv_q, wv_d;
  logic                  err_q, err_d;

  // Query walk: offset counters, read stage and the held filled neighbor.
  logic [1:0]            dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic                  iss_done_q, iss_done_d;
  logic                  s1_valid_q, s1_valid_d;
  logic [COORD_W-1:0]    s1_x_q, s1_x_d, s1_y_q, s1_y_d, s1_z_q, s1_z_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [COORD_W-1:0]    pend_x_q, pend_x_d, pend_y_q, pend_y_d, pend_z_q, pend_z_d;

  // Output register.
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_rv_q;
  logic                  out_found_q;
  logic [COORD_W-1:0]    out_x_q, out_y_q, out_z_q;
  logic [OUT_W-1:0]      out_total_q;
  logic                  out_status_q;
  logic                  out_last_q;

  // Result produced this cycle.
  logic                  push;
  logic [OUT_W-1:0]      push_rv;
  logic                  push_found;
  logic [COORD_W-1:0]    push_x, push_y, push_z;
  logic                  push_status;
  logic                  push_last;

  // Store port.
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
  logic                  ram_filled;

  loc_t                  loc;
  logic [ADDR_W-1:0]     loc_addr;
  logic                  out_free;
  logic                  stall;
  logic                  centre;
  logic                  issue_ok;

  vgnq_addr #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_addr (
    .clk_i    (clk_i),
    .size_x_i (size_x_q),
    .size_y_i (size_y_q),
    .size_z_i (size_z_q),
    .cx_i     (cx_q),
    .cy_i     (cy_q),
    .cz_i     (cz_q),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .dz_i     (dz_q),
    .loc_o    (loc),
    .addr_o   (loc_addr)
  );

  vgnq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Size registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_W'(32);
      size_y_q <= SIZE_W'(32);
      size_z_q <= SIZE_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIZE_X: size_x_q <= cfg_data_i;
        REG_SIZE_Y: size_y_q <= cfg_data_i;
        REG_SIZE_Z: size_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign ram_filled = (ram_rdata != '0);
  assign centre     = (dx_q == OFS_MID) && (dy_q == OFS_MID) && (dz_q == OFS_MID);
  assign stall      = s1_valid_q && ram_filled && pend_valid_q && !out_free;
  assign issue_ok   = loc.in_grid && !centre;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: clearing sweep, single accesses and the neighbor walk.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cnt_d        = cnt_q;
    cmd_d        = cmd_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    cz_d         = cz_q;
    wv_d         = wv_q;
    err_d        = err_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    dz_d         = dz_q;
    iss_done_d   = iss_done_q;
    s1_valid_d   = s1_valid_q;
    s1_x_d       = s1_x_q;
    s1_y_d       = s1_y_q;
    s1_z_d       = s1_z_q;
    pend_valid_d = pend_valid_q;
    pend_x_d     = pend_x_q;
    pend_y_d     = pend_y_q;
    pend_z_d     = pend_z_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = loc_addr;
    ram_wdata    = wv_q;
    push         = 1'b0;
    push_rv      = '0;
    push_found   = 1'b0;
    push_x       = '0;
    push_y       = '0;
    push_z       = '0;
    push_status  = 1'b0;
    push_last    = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_addr  = clr_q;
        ram_we    = 1'b1;
        ram_wdata = '0;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          cx_d    = coord_x_i;
          cy_d    = coord_y_i;
          cz_d    = coord_z_i;
          wv_d    = VALUE_BITS'(write_value_i);
          dx_d    = OFS_MID;
          dy_d    = OFS_MID;
          dz_d    = OFS_MID;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_q == CMD_QUERY) begin
          dx_d         = OFS_LO;
          dy_d         = OFS_LO;
          dz_d         = OFS_LO;
          iss_done_d   = 1'b0;
          s1_valid_d   = 1'b0;
          pend_valid_d = 1'b0;
          state_d      = S_QUERY;
        end else begin
          // The centre voxel is read for a write (old value), a read or a count (unused).
          err_d   = ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)) && !loc.in_grid;
          ram_re  = loc.in_grid;
          state_d = S_DATA;
        end
      end

      S_DATA: begin
        if (out_free) begin
          push        = 1'b1;
          push_last   = 1'b1;
          push_status = err_q;
          if ((cmd_q == CMD_READ) && !err_q) begin
            push_rv = OUT_W'(ram_rdata);
          end
          if ((cmd_q == CMD_WRITE) && !err_q) begin
            ram_we = 1'b1;
            if (!ram_filled && (wv_q != '0)) begin
              cnt_d = cnt_q + CNT_W'(1);
            end else if (ram_filled && (wv_q == '0) && (cnt_q != '0)) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
          state_d = S_IDLE;
        end
      end

      S_QUERY: begin
        if (!stall) begin
          // Check the neighbor in the read stage; hold a filled one until the next
          // filled one or the end of the walk shows whether it is the final result.
          if (s1_valid_q && ram_filled) begin
            if (pend_valid_q) begin
              push       = 1'b1;
              push_found = 1'b1;
              push_x     = pend_x_q;
              push_y     = pend_y_q;
              push_z     = pend_z_q;
            end
            pend_valid_d = 1'b1;
            pend_x_d     = s1_x_q;
            pend_y_d     = s1_y_q;
            pend_z_d     = s1_z_q;
          end
          if (!iss_done_q) begin
            // Issue the read of the next offset, z outermost, x innermost.
            s1_valid_d = issue_ok;
            ram_re     = issue_ok;
            s1_x_d     = loc.x[COORD_W-1:0];
            s1_y_d     = loc.y[COORD_W-1:0];
            s1_z_d     = loc.z[COORD_W-1:0];
            if (dx_q == OFS_HI) begin
              dx_d = OFS_LO;
              if (dy_q == OFS_HI) begin
                dy_d = OFS_LO;
                dz_d = dz_q + 2'd1;
              end else begin
                dy_d = dy_q + 2'd1;
              end
            end else begin
              dx_d = dx_q + 2'd1;
            end
            if ((dx_q == OFS_HI) && (dy_q == OFS_HI) && (dz_q == OFS_HI)) begin
              iss_done_d = 1'b1;
            end
          end else begin
            s1_valid_d = 1'b0;
            // Walk drained: send the held neighbor, or a not-found result.
            if (!s1_valid_q && out_free) begin
              push      = 1'b1;
              push_last = 1'b1;
              if (pend_valid_q) begin
                push_found = 1'b1;
                push_x     = pend_x_q;
                push_y     = pend_y_q;
                push_z     = pend_z_q;
              end
              pend_valid_d = 1'b0;
              state_d      = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      cnt_q        <= '0;
      dx_q         <= OFS_MID;
      dy_q         <= OFS_MID;
      dz_q         <= OFS_MID;
      iss_done_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      err_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      dz_q         <= dz_d;
      iss_done_q   <= iss_done_d;
      s1_valid_q   <= s1_valid_d;
      pend_valid_q <= pend_valid_d;
      err_q        <= err_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    wv_q     <= wv_d;
    s1_x_q   <= s1_x_d;
    s1_y_q   <= s1_y_d;
    s1_z_q   <= s1_z_d;
    pend_x_q <= pend_x_d;
    pend_y_q <= pend_y_d;
    pend_z_q <= pend_z_d;
  end

  // Output register: loaded on a new result, emptied on a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_rv_q     <= push_rv;
      out_found_q  <= push_found;
      out_x_q      <= push_x;
      out_y_q      <= push_y;
      out_z_q      <= push_z;
      out_total_q  <= OUT_W'(cnt_d);
      out_status_q <= push_status;
      out_last_q   <= push_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_rv_q;
  assign found_o        = out_found_q;
  assign nbr_x_o        = out_x_q;
  assign nbr_y_o        = out_y_q;
  assign nbr_z_o        = out_z_q;
  assign filled_total_o = out_total_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  // A new result is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result loaded over an untaken result");

  // The store is never written during a neighbor walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUERY) |-> !ram_we)
    else $error("store write during neighbor query");

  // The filled count never exceeds the number of store entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("filled count out of range");

  // The final result of a command returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_last) |=> (state_q == S_IDLE))
    else $error("sequencer not idle after final result");

  // A stalled walk keeps its read data for the check that follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(ram_rdata))
    else $error("read data lost during stall");

endmodule
`default_nettype wire
